>>> rtl/core/rgb_to_hsl_converter_macros.svh
// Assertion macros used by the checker file of the converter.
// No dependencies.
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// Antecedent implies consequent in the same cycle, reset masked.
`define RTHSL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rthsl assertion failed");

// Antecedent implies consequent in the next cycle, reset masked.
`define RTHSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rthsl assertion failed");

// Antecedent implies consequent in the next cycle, reset not masked.
`define RTHSL_ASSERT_NEXT_RAW(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rthsl assertion failed");

`endif

>>> rtl/core/rthsl_pkg.sv
// Types and constants of the RGB to HSL converter.
// No dependencies.
`default_nettype none

package rthsl_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned FRAC_W = 16;
  // quotient carries one bit above the fraction to catch 1.0
  localparam int unsigned QUO_W  = FRAC_W + 1;
  localparam int unsigned DEN_W  = 11;          // up to 6 * 255
  localparam int unsigned REM_W  = DEN_W + 1;   // holds up to 2*den
  localparam int unsigned NUM_CELLS = QUO_W;
  localparam int unsigned NUM_LANES = 3;

  localparam logic [DEN_W-1:0] LIG_DEN = DEN_W'(510);
  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  typedef enum logic [1:0] {
    LANE_HUE = 2'd0,
    LANE_SAT = 2'd1,
    LANE_LIG = 2'd2
  } lane_sel_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic                      grey;
    lane_t [NUM_LANES-1:0]     lane;
  } cell_t;

  // Q0.16 result with saturation at 1.0
  function automatic logic [FRAC_W-1:0] sat_frac(input logic [QUO_W-1:0] q);
    sat_frac = q[QUO_W-1] ? FRAC_MAX : q[FRAC_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rthsl_stream_if.sv
// Stream interfaces of the converter: RGB pixel in, HSL result out.
// Uses rthsl_pkg for field widths.
`default_nettype none

interface rthsl_rgb_if;
  logic                          valid;
  logic                          ready;
  logic [rthsl_pkg::CHAN_W-1:0]  red;
  logic [rthsl_pkg::CHAN_W-1:0]  green;
  logic [rthsl_pkg::CHAN_W-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rthsl_hsl_if;
  logic                          valid;
  logic                          ready;
  logic [rthsl_pkg::FRAC_W-1:0]  hue;
  logic [rthsl_pkg::FRAC_W-1:0]  saturation;
  logic [rthsl_pkg::FRAC_W-1:0]  lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rthsl_prep.sv
// Front stage: max/min, sector numerator and divisors for three dividers.
// Uses rthsl_pkg.
`default_nettype none

module rthsl_prep (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          up_valid,
  output logic                               up_ready,
  input  wire logic [rthsl_pkg::CHAN_W-1:0]  red,
  input  wire logic [rthsl_pkg::CHAN_W-1:0]  green,
  input  wire logic [rthsl_pkg::CHAN_W-1:0]  blue,
  output logic                               dn_valid,
  input  wire logic                          dn_ready,
  output rthsl_pkg::cell_t                   dn_data
);

  localparam int unsigned DW = rthsl_pkg::DEN_W;
  localparam int unsigned RW = rthsl_pkg::REM_W;

  logic [rthsl_pkg::CHAN_W-1:0] hi, lo;
  logic [DW-1:0] r_x, g_x, b_x, hi_x, lo_x, d_x, s_x, n_hue, den_hue, den_sat;
  rthsl_pkg::cell_t data_next;

  always_comb begin
    hi = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    r_x  = DW'(red);
    g_x  = DW'(green);
    b_x  = DW'(blue);
    hi_x = DW'(hi);
    lo_x = DW'(lo);
    d_x  = hi_x - lo_x;
    s_x  = hi_x + lo_x;
    den_hue = (d_x << 2) + (d_x << 1);
    den_sat = (s_x > DW'(255)) ? (rthsl_pkg::LIG_DEN - s_x) : s_x;
    // sector numerator, wraps to a non-negative value in modular arithmetic
    if (hi == red) begin
      n_hue = (green >= blue) ? (g_x - b_x) : (den_hue - (b_x - g_x));
    end else if (hi == green) begin
      n_hue = (d_x << 1) + b_x - r_x;
    end else begin
      n_hue = (d_x << 2) + r_x - g_x;
    end

    data_next.grey = (d_x == '0);
    data_next.lane[rthsl_pkg::LANE_HUE].den = den_hue;
    data_next.lane[rthsl_pkg::LANE_HUE].rem = RW'(n_hue);
    data_next.lane[rthsl_pkg::LANE_HUE].quo = '0;
    data_next.lane[rthsl_pkg::LANE_SAT].den = den_sat;
    data_next.lane[rthsl_pkg::LANE_SAT].rem = RW'(d_x);
    data_next.lane[rthsl_pkg::LANE_SAT].quo = '0;
    data_next.lane[rthsl_pkg::LANE_LIG].den = rthsl_pkg::LIG_DEN;
    data_next.lane[rthsl_pkg::LANE_LIG].rem = RW'(s_x);
    data_next.lane[rthsl_pkg::LANE_LIG].quo = '0;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rthsl_div_cell.sv
// One cell of the divider chain: one quotient bit for each of the three lanes.
// Uses rthsl_pkg.
`default_nettype none

module rthsl_div_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire rthsl_pkg::cell_t  up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output rthsl_pkg::cell_t       dn_data
);

  localparam int unsigned RW = rthsl_pkg::REM_W;

  rthsl_pkg::cell_t data_next;

  // restoring step: compare, subtract, then shift for the next bit
  always_comb begin
    logic [RW-1:0] den_x, diff;
    logic          take;
    data_next = up_data;
    for (int i = 0; i < int'(rthsl_pkg::NUM_LANES); i++) begin
      den_x = RW'(up_data.lane[i].den);
      take  = (up_data.lane[i].rem >= den_x);
      diff  = take ? (up_data.lane[i].rem - den_x) : up_data.lane[i].rem;
      data_next.lane[i].rem = diff << 1;
      data_next.lane[i].quo = {up_data.lane[i].quo[rthsl_pkg::QUO_W-2:0], take};
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rgb_to_hsl_converter.sv
// RGB to HSL converter: takes one 8-bit RGB pixel per request and returns hue,
// saturation and lightness as unsigned Q0.16 fractions, truncated, with 1.0
// clamped to 0xFFFF. Grey pixels give zero hue and saturation. The block
// accepts one pixel per clock unless a stalled output has filled the chain,
// and an accepted input passes through one front stage (max/min, hue sector,
// divisors) and a chain of 17 division cells, each producing one quotient
// bit for the hue, saturation and lightness dividers at once. Every stage has
// its own valid bit and ready is formed stage by stage, so a stalled output
// only holds back the input once the chain has no empty stage left. The last
// cell is the output register. No configuration, no state between pixels.
// Uses rthsl_pkg, rthsl_stream_if, rthsl_prep and rthsl_div_cell.
`default_nettype none

module rgb_to_hsl_converter (
  input  wire logic  clk,
  input  wire logic  rst,
  rthsl_rgb_if.sink  pix,
  rthsl_hsl_if.source hsl
);

  localparam int unsigned N = rthsl_pkg::NUM_CELLS;

  // stage 0 is the front stage; stage k+1 is the output of cell k
  logic             stage_valid [0:N];
  logic             stage_ready [0:N];
  rthsl_pkg::cell_t stage_data  [0:N];

  rthsl_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pix.valid),
    .up_ready (pix.ready),
    .red      (pix.red),
    .green    (pix.green),
    .blue     (pix.blue),
    .dn_valid (stage_valid[0]),
    .dn_ready (stage_ready[0]),
    .dn_data  (stage_data[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    rthsl_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[k]),
      .up_ready (stage_ready[k]),
      .up_data  (stage_data[k]),
      .dn_valid (stage_valid[k+1]),
      .dn_ready (stage_ready[k+1]),
      .dn_data  (stage_data[k+1])
    );
  end

  assign stage_ready[N] = hsl.ready;
  assign hsl.valid      = stage_valid[N];

  // quotient bit 16 set means the value reached 1.0; grey forces zero hue and saturation
  assign hsl.hue = stage_data[N].grey ? '0 :
      rthsl_pkg::sat_frac(stage_data[N].lane[rthsl_pkg::LANE_HUE].quo);
  assign hsl.saturation = stage_data[N].grey ? '0 :
      rthsl_pkg::sat_frac(stage_data[N].lane[rthsl_pkg::LANE_SAT].quo);
  assign hsl.lightness =
      rthsl_pkg::sat_frac(stage_data[N].lane[rthsl_pkg::LANE_LIG].quo);

endmodule

`default_nettype wire

>>> rtl/core/rthsl_checker.sv
// Port-level checks of the converter, bound to the top level.
// Uses rgb_to_hsl_converter_macros.svh and rthsl_pkg.
`default_nettype none
`include "rgb_to_hsl_converter_macros.svh"

module rthsl_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [rthsl_pkg::FRAC_W-1:0] hue,
  input wire logic [rthsl_pkg::FRAC_W-1:0] saturation
);

  // a stalled result stays offered
  `RTHSL_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && !out_ready, out_valid)
  // pipeline comes out of reset empty
  `RTHSL_ASSERT_NEXT_RAW(a_reset_empty, clk, rst, !out_valid)
  // zero saturation only for grey pixels, which have zero hue
  `RTHSL_ASSERT_SAME(a_grey_hue, clk, rst, out_valid && saturation == '0, hue == '0)

endmodule

bind rgb_to_hsl_converter rthsl_checker u_rthsl_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (hsl.valid),
  .out_ready  (hsl.ready),
  .hue        (hsl.hue),
  .saturation (hsl.saturation)
);

`default_nettype wire
